@@ rtl/crp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_pkg
// shared widths, character codes, status codes and stage structs of the
// cell reference parser
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int CHAR_W     = 8;
  localparam int COL_VAL_W  = 15;  // holds up to three letters, ZZZ = 18278
  localparam int ROW_VAL_W  = 21;  // holds the saturated row, MAX_ROW + 1
  localparam int ROW_PROD_W = 25;  // row times ten plus one digit
  localparam int COL_IDX_W  = 14;
  localparam int ROW_IDX_W  = 20;
  localparam int CNT_W      = 2;

  localparam logic [CNT_W-1:0] MAX_LETTERS = 2'd3;
  localparam logic [4:0]       COL_RADIX   = 5'd26;

  localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;  // '$'
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;  // 'z'

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_CHAR    = 3'd1,
    ST_NO_DIGITS   = 3'd2,
    ST_BAD_LETTERS = 3'd3,
    ST_RANGE       = 3'd4
  } status_t;

  // one character request
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } req_t;

  // one finished result
  typedef struct packed {
    logic [COL_IDX_W-1:0] col_idx;
    logic [ROW_IDX_W-1:0] row_idx;
    logic                 column_absolute;
    logic                 row_absolute;
    status_t              status;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/crp_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_in_reg
// input register: holds one character request until the parser takes it
// ----------------------------------------------------------------------------
module crp_in_reg
  import crp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire req_t  req_in,
  input  wire logic  advance,
  output logic       held_valid,
  output req_t       held_req
);

  logic load;

  assign in_ready = !held_valid || advance;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_req <= req_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/crp_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_parser
// grammar state machine, column and row accumulators, and the result check
// ----------------------------------------------------------------------------
module crp_parser
  import crp_pkg::*;
#(
  parameter int MAX_ROW    = 1048576,
  parameter int MAX_COLUMN = 16384
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire req_t req,
  output res_t      res,
  output logic      busy
);

  typedef enum logic [2:0] {
    PH_START,
    PH_AFTER_CDOLLAR,
    PH_LETTERS,
    PH_AFTER_RDOLLAR,
    PH_DIGITS
  } phase_t;

  localparam logic [ROW_PROD_W-1:0] ROW_SAT_W = ROW_PROD_W'(MAX_ROW + 1);
  localparam logic [ROW_VAL_W-1:0]  ROW_SAT   = ROW_VAL_W'(MAX_ROW + 1);
  localparam logic [ROW_VAL_W-1:0]  ROW_MAX   = ROW_VAL_W'(MAX_ROW);
  localparam logic [COL_VAL_W-1:0]  COL_MAX   = COL_VAL_W'(MAX_COLUMN);

  phase_t               phase, phase_next;
  logic [COL_VAL_W-1:0] column_value, column_value_next;
  logic [CNT_W-1:0]     letter_count, letter_count_next;
  logic [ROW_VAL_W-1:0] row_value, row_value_next;
  logic                 column_dollar_seen, column_dollar_seen_next;
  logic                 row_dollar_seen, row_dollar_seen_next;
  status_t              error_latch, error_latch_next;

  logic                  is_letter, is_digit, is_dollar;
  logic                  do_letter, do_digit;
  logic [4:0]            letter_val;
  logic [COL_VAL_W-1:0]  column_acc;
  logic [ROW_PROD_W-1:0] row_prod;
  logic [COL_VAL_W-1:0]  column_m1;
  logic [ROW_VAL_W-1:0]  row_m1;
  status_t               status;

  assign is_letter = (req.char_code >= CH_UPPER_A && req.char_code <= CH_UPPER_Z) ||
                     (req.char_code >= CH_LOWER_A && req.char_code <= CH_LOWER_Z);
  assign is_digit  = req.char_code >= CH_ZERO && req.char_code <= CH_NINE;
  assign is_dollar = req.char_code == CH_DOLLAR;

  // both cases of a letter carry its alphabet position in the low five bits
  assign letter_val = req.char_code[4:0];
  assign column_acc = COL_VAL_W'(column_value * COL_RADIX) + COL_VAL_W'(letter_val);
  assign row_prod   = ROW_PROD_W'(row_value) * ROW_PROD_W'(10) +
                      ROW_PROD_W'(req.char_code[3:0]);

  always_comb begin
    phase_next              = phase;
    column_value_next       = column_value;
    letter_count_next       = letter_count;
    row_value_next          = row_value;
    column_dollar_seen_next = column_dollar_seen;
    row_dollar_seen_next    = row_dollar_seen;
    error_latch_next        = error_latch;
    do_letter               = 1'b0;
    do_digit                = 1'b0;

    if (error_latch == ST_OK) begin
      unique case (phase)
        PH_START: begin
          if (is_dollar) begin
            column_dollar_seen_next = 1'b1;
            phase_next              = PH_AFTER_CDOLLAR;
          end else if (is_letter) begin
            do_letter = 1'b1;
          end else if (is_digit) begin
            error_latch_next = ST_BAD_LETTERS;
          end else begin
            error_latch_next = ST_BAD_CHAR;
          end
        end
        PH_AFTER_CDOLLAR: begin
          if (is_letter) begin
            do_letter = 1'b1;
          end else if (is_digit) begin
            error_latch_next = ST_BAD_LETTERS;
          end else begin
            error_latch_next = ST_BAD_CHAR;
          end
        end
        PH_LETTERS: begin
          if (is_letter) begin
            do_letter = 1'b1;
          end else if (is_dollar) begin
            row_dollar_seen_next = 1'b1;
            phase_next           = PH_AFTER_RDOLLAR;
          end else if (is_digit) begin
            do_digit = 1'b1;
          end else begin
            error_latch_next = ST_BAD_CHAR;
          end
        end
        PH_AFTER_RDOLLAR, PH_DIGITS: begin
          if (is_digit) begin
            do_digit = 1'b1;
          end else begin
            error_latch_next = ST_BAD_CHAR;
          end
        end
        default: begin
          error_latch_next = ST_BAD_CHAR;
        end
      endcase

      if (do_letter) begin
        if (letter_count == MAX_LETTERS) begin
          error_latch_next = ST_BAD_LETTERS;
        end else begin
          column_value_next = column_acc;
          letter_count_next = letter_count + CNT_W'(1);
          phase_next        = PH_LETTERS;
        end
      end

      if (do_digit) begin
        row_value_next = (row_prod > ROW_SAT_W) ? ROW_SAT : row_prod[ROW_VAL_W-1:0];
        phase_next     = PH_DIGITS;
      end
    end
  end

  // status as seen after this character
  always_comb begin
    if (error_latch_next != ST_OK) begin
      status = error_latch_next;
    end else if (phase_next == PH_START || phase_next == PH_AFTER_CDOLLAR) begin
      status = ST_BAD_LETTERS;
    end else if (phase_next != PH_DIGITS) begin
      status = ST_NO_DIGITS;
    end else if (row_value_next == '0 || row_value_next > ROW_MAX ||
                 column_value_next == '0 || column_value_next > COL_MAX) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
    end
  end

  assign column_m1 = column_value_next - COL_VAL_W'(1);
  assign row_m1    = row_value_next - ROW_VAL_W'(1);

  always_comb begin
    res = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.col_idx         = column_m1[COL_IDX_W-1:0];
      res.row_idx         = row_m1[ROW_IDX_W-1:0];
      res.column_absolute = column_dollar_seen_next;
      res.row_absolute    = row_dollar_seen_next;
    end
  end

  assign busy = phase != PH_START || error_latch != ST_OK || column_dollar_seen;

  always_ff @(posedge clk) begin
    if (rst || (advance && req.last)) begin
      phase              <= PH_START;
      column_value       <= '0;
      letter_count       <= '0;
      row_value          <= '0;
      column_dollar_seen <= 1'b0;
      row_dollar_seen    <= 1'b0;
      error_latch        <= ST_OK;
    end else if (advance) begin
      phase              <= phase_next;
      column_value       <= column_value_next;
      letter_count       <= letter_count_next;
      row_value          <= row_value_next;
      column_dollar_seen <= column_dollar_seen_next;
      row_dollar_seen    <= row_dollar_seen_next;
      error_latch        <= error_latch_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/crp_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_out_reg
// result register: holds one result until the consumer takes it
// ----------------------------------------------------------------------------
module crp_out_reg
  import crp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire res_t res_in,
  input  wire logic out_ready,
  output logic      out_valid,
  output res_t      res_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cell_reference_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cell_reference_parser
// A1 spreadsheet cell reference parser, one character per request
// ----------------------------------------------------------------------------
// The block reads a reference such as "B12", "$C$7" or "aa100" one character
// per request, with last set on the final character, and gives exactly one
// result for each reference: zero-based column and row, the two absolute
// flags and a status (0 ok, 1 bad character, 2 no row digits, 3 bad letter
// count, 4 out of range; on any nonzero status the other fields are zero).
// The first error in a reference wins and the rest of its characters are
// swallowed. A character request is taken every cycle unless both registers
// are full and the result side stalls; each one passes through an input
// register and the parser logic, and the result of the last character lands
// in the result register as that character leaves the input register. The
// parser state updates once per cycle while characters move on; a stall on the
// result side only blocks input once the result and input registers are full.
// ----------------------------------------------------------------------------
module cell_reference_parser
  import crp_pkg::*;
#(
  parameter int MAX_ROW    = 1048576,
  parameter int MAX_COLUMN = 16384
)
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // character requests
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CHAR_W-1:0]    char_code,
  input  wire logic                 last,
  // results
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [COL_IDX_W-1:0]      col_idx,
  output logic [ROW_IDX_W-1:0]      row_idx,
  output logic                      column_absolute,
  output logic                      row_absolute,
  output logic [2:0]                status
);

  req_t req_in;
  req_t held_req;
  logic held_valid;
  logic advance;
  logic emit;
  logic parse_busy;
  res_t parse_res;
  res_t out_res;

  assign req_in.char_code = char_code;
  assign req_in.last      = last;

  // the held character moves on whenever the result register can take a result
  assign advance = held_valid && (!out_valid || out_ready);
  // only the last character of a reference produces a result
  assign emit    = advance && held_req.last;

  crp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_in     (req_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_req   (held_req)
  );

  crp_parser #(
    .MAX_ROW    (MAX_ROW),
    .MAX_COLUMN (MAX_COLUMN)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (held_req),
    .res     (parse_res),
    .busy    (parse_busy)
  );

  crp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .res_in    (parse_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign col_idx         = out_res.col_idx;
  assign row_idx         = out_res.row_idx;
  assign column_absolute = out_res.column_absolute;
  assign row_absolute    = out_res.row_absolute;
  assign status          = out_res.status;

  // input only stalls when both registers are full and the consumer is stalled
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> held_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");

  // a reference that ends leaves the parser back at its start
  assert property (@(posedge clk) disable iff (rst)
    emit |=> !parse_busy)
    else $error("parser state not cleared after the last character");

  // an error result carries no position or flags
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      col_idx == '0 && row_idx == '0 && !column_absolute && !row_absolute)
    else $error("error result with nonzero fields");

  // a new result is only loaded once the previous one is gone
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

@@ dv/reference_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reference_result_checker
// watches both channels of the cell reference parser, predicts each result
// from the accepted characters and compares it field by field
// ----------------------------------------------------------------------------
module reference_result_checker
  import crp_pkg::*;
#(
  parameter int MAX_ROW    = 1048576,
  parameter int MAX_COLUMN = 16384
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic                 last,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [COL_IDX_W-1:0] col_idx,
  input  logic [ROW_IDX_W-1:0] row_idx,
  input  logic                 column_absolute,
  input  logic                 row_absolute,
  input  logic [2:0]           status,
  output int                   error_count,
  output int                   pending_count,
  output int                   checked_count
);

  typedef enum logic [2:0] {
    PH_START,
    PH_COL_DOLLAR,
    PH_LETTERS,
    PH_ROW_DOLLAR,
    PH_DIGITS
  } parse_phase_t;

  parse_phase_t         phase;
  logic [COL_VAL_W-1:0] col_value;
  logic [2:0]           letter_count;
  logic [ROW_VAL_W-1:0] row_value;
  logic                 col_dollar;
  logic                 row_dollar;
  status_t              fault;

  res_t predicted_results[$];
  int   fails;
  int   checked;

  task clear_parser();
    phase        = PH_START;
    col_value    = '0;
    letter_count = '0;
    row_value    = '0;
    col_dollar   = 1'b0;
    row_dollar   = 1'b0;
    fault        = ST_OK;
  endtask

  task take_letter(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] upper;
    upper = (c >= CH_LOWER_A) ? c - 8'd32 : c;
    if (letter_count >= MAX_LETTERS) begin
      fault = ST_BAD_LETTERS;
    end else begin
      col_value    = col_value * COL_RADIX + COL_VAL_W'(upper - CH_UPPER_A + 8'd1);
      letter_count = letter_count + 3'd1;
      phase        = PH_LETTERS;
    end
  endtask

  task take_digit(input logic [CHAR_W-1:0] c);
    int unsigned row_next;
    row_next = row_value * 10 + (c - CH_ZERO);
    // row saturates one past the largest legal row
    if (row_next > MAX_ROW + 1) row_next = MAX_ROW + 1;
    row_value = ROW_VAL_W'(row_next);
    phase     = PH_DIGITS;
  endtask

  task advance_parser(input logic [CHAR_W-1:0] c, input logic fin,
                      output logic produced, output res_t outcome);
    logic    is_letter;
    logic    is_digit;
    logic    is_dollar;
    status_t verdict;
    is_letter = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    is_digit  = (c >= CH_ZERO && c <= CH_NINE);
    is_dollar = (c == CH_DOLLAR);
    produced  = 1'b0;
    outcome   = '0;
    // first error wins, the rest of the reference is swallowed
    if (fault == ST_OK) begin
      case (phase)
        PH_START: begin
          if (is_dollar) begin
            col_dollar = 1'b1;
            phase      = PH_COL_DOLLAR;
          end else if (is_letter) take_letter(c);
          else if (is_digit) fault = ST_BAD_LETTERS;
          else fault = ST_BAD_CHAR;
        end
        PH_COL_DOLLAR: begin
          if (is_letter) take_letter(c);
          else if (is_digit) fault = ST_BAD_LETTERS;
          else fault = ST_BAD_CHAR;
        end
        PH_LETTERS: begin
          if (is_letter) take_letter(c);
          else if (is_dollar) begin
            row_dollar = 1'b1;
            phase      = PH_ROW_DOLLAR;
          end else if (is_digit) take_digit(c);
          else fault = ST_BAD_CHAR;
        end
        PH_ROW_DOLLAR, PH_DIGITS: begin
          if (is_digit) take_digit(c);
          else fault = ST_BAD_CHAR;
        end
        default: fault = ST_BAD_CHAR;
      endcase
    end
    if (fin) begin
      if (fault != ST_OK) verdict = fault;
      else if (phase == PH_START || phase == PH_COL_DOLLAR) verdict = ST_BAD_LETTERS;
      else if (phase != PH_DIGITS) verdict = ST_NO_DIGITS;
      else if (row_value == 0 || row_value > MAX_ROW ||
               col_value == 0 || col_value > MAX_COLUMN) verdict = ST_RANGE;
      else verdict = ST_OK;
      if (verdict == ST_OK) begin
        outcome.col_idx         = COL_IDX_W'(col_value - 1);
        outcome.row_idx         = ROW_IDX_W'(row_value - 1);
        outcome.column_absolute = col_dollar;
        outcome.row_absolute    = row_dollar;
      end
      outcome.status = verdict;
      produced       = 1'b1;
      clear_parser();
    end
  endtask

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    logic produced;
    res_t outcome;
    res_t oldest;
    int   bad;
    if (rst) begin
      clear_parser();
      predicted_results.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (in_valid && in_ready) begin
        advance_parser(char_code, last, produced, outcome);
        if (produced) predicted_results.push_back(outcome);
      end
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, status);
          fails++;
        end else begin
          oldest = predicted_results.pop_front();
          bad = field_differs("col_idx", oldest.col_idx, col_idx)
              + field_differs("row_idx", oldest.row_idx, row_idx)
              + field_differs("column_absolute", oldest.column_absolute, column_absolute)
              + field_differs("row_absolute", oldest.row_absolute, row_absolute)
              + field_differs("status", oldest.status, status);
          if (bad != 0) fails++;
          checked++;
        end
      end
    end
    error_count   <= fails;
    pending_count <= predicted_results.size();
    checked_count <= checked;
  end

endmodule

@@ dv/tb_cell_reference_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cell_reference_parser
// stimulus and verdict for the A1 cell reference parser
// ----------------------------------------------------------------------------
// Directed references hit the corners of the grammar first, then random
// references, mostly well formed with random content and the rest broken or
// pure noise, run through the block. A separate checker predicts and compares
// every result. Both sides idle at random, with one stretch free of idling,
// and the result side holds off twice for a long stretch so the block fills up.
// ----------------------------------------------------------------------------
module tb_cell_reference_parser;
  import crp_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RANDOM_CHARS  = 1100;
  localparam int HOLD_CYCLES   = 120;
  localparam int DRAIN_CYCLES  = 10;
  localparam int LIMIT_CYCLES  = 200000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [CHAR_W-1:0]    char_code;
  logic                 last;
  logic                 out_valid;
  logic                 out_ready;
  logic [COL_IDX_W-1:0] col_idx;
  logic [ROW_IDX_W-1:0] row_idx;
  logic                 column_absolute;
  logic                 row_absolute;
  logic [2:0]           status;

  int error_count;
  int pending_count;
  int checked_count;

  // knobs shared by the sender and the receiver, written with nonblocking
  // assignments at the falling edge so the receiver reads them cleanly
  logic quiet_mode;
  int   hold_off_req;

  logic [CHAR_W-1:0] ref_text[$];
  int                chars_sent;
  int                refs_sent;

  cell_reference_parser dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .char_code       (char_code),
    .last            (last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .col_idx         (col_idx),
    .row_idx         (row_idx),
    .column_absolute (column_absolute),
    .row_absolute    (row_absolute),
    .status          (status)
  );

  reference_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .char_code       (char_code),
    .last            (last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .col_idx         (col_idx),
    .row_idx         (row_idx),
    .column_absolute (column_absolute),
    .row_absolute    (row_absolute),
    .status          (status),
    .error_count     (error_count),
    .pending_count   (pending_count),
    .checked_count   (checked_count)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // hard stop in case the handshake hangs
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAIL");
    $finish;
  end

  // one character request; entered and left at a falling edge
  task send_char(input logic [CHAR_W-1:0] c, input logic fin);
    // sender gap before roughly one character in twenty
    if (!quiet_mode && $urandom_range(0, 99) < 5) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last      <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  // whole reference in ref_text, last marked on the final character
  task send_reference();
    for (int i = 0; i < ref_text.size(); i++) begin
      send_char(ref_text[i], i == ref_text.size() - 1);
    end
    refs_sent++;
  endtask

  task send_string(input string s);
    ref_text.delete();
    for (int i = 0; i < s.len(); i++) ref_text.push_back(s[i]);
    send_reference();
  endtask

  // letter by alphabet index, random case
  task push_letter(input int idx);
    ref_text.push_back(CHAR_W'(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + idx));
  endtask

  task push_decimal(input int unsigned v);
    logic [CHAR_W-1:0] digits[$];
    digits.delete();
    do begin
      digits.push_front(CHAR_W'(CH_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) ref_text.push_back(digits[i]);
  endtask

  task push_row_digits();
    int n;
    // occasional leading zero, which must not change the row
    if ($urandom_range(0, 7) == 0) ref_text.push_back(CH_ZERO);
    case ($urandom_range(0, 9))
      0: push_decimal(1048576);                       // largest row
      1: push_decimal(1048577);                       // one past it
      2: push_decimal(0);                             // row zero
      3: push_decimal($urandom_range(1000000, 9999999));
      4: begin
        // long digit runs push the row into saturation
        n = $urandom_range(8, 11);
        ref_text.push_back(CHAR_W'(CH_ZERO + $urandom_range(1, 9)));
        for (int k = 1; k < n; k++) ref_text.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
      end
      5, 6: push_decimal($urandom_range(1, 99));
      default: push_decimal($urandom_range(1, 99999));
    endcase
  endtask

  task build_well_formed(input int letter_n, input logic with_digits);
    if ($urandom_range(0, 1)) ref_text.push_back(CH_DOLLAR);
    if (letter_n == 3 && $urandom_range(0, 5) == 0) begin
      // column corners: last legal column, one past it, and the widest code
      case ($urandom_range(0, 2))
        0: begin push_letter(23); push_letter(5); push_letter(3); end
        1: begin push_letter(23); push_letter(5); push_letter(4); end
        default: begin push_letter(25); push_letter(25); push_letter(25); end
      endcase
    end else begin
      for (int k = 0; k < letter_n; k++) push_letter($urandom_range(0, 25));
    end
    if ($urandom_range(0, 1)) ref_text.push_back(CH_DOLLAR);
    if (with_digits) push_row_digits();
  endtask

  task build_random_reference();
    int pos;
    ref_text.delete();
    if ($urandom_range(0, 99) < 75) begin
      build_well_formed($urandom_range(1, 3), 1'b1);
    end else begin
      case ($urandom_range(0, 6))
        0: begin
          // one character replaced by any byte at all
          build_well_formed($urandom_range(1, 3), 1'b1);
          pos = $urandom_range(0, ref_text.size() - 1);
          ref_text[pos] = CHAR_W'($urandom_range(0, 255));
        end
        1: build_well_formed(4, 1'b1);                     // fourth letter
        2: build_well_formed($urandom_range(1, 3), 1'b0);  // no row digits
        3: build_well_formed(0, 1'b1);                     // digits with no letters
        4: begin
          build_well_formed($urandom_range(1, 3), 1'b1);
          ref_text.push_front(CH_DOLLAR);                  // dollar up front, a second one if the column had one
        end
        5: begin
          build_well_formed($urandom_range(1, 3), 1'b1);
          push_letter($urandom_range(0, 25));              // letter after digits
        end
        default: begin
          // pure noise across the whole byte range
          repeat ($urandom_range(1, 4)) ref_text.push_back(CHAR_W'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // result side: random stalls, a quiet stretch, and long hold-offs on request
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else if (quiet_mode) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // stimulus, drain and verdict
  initial begin
    int random_chars;
    rst          = 1'b1;
    in_valid     = 1'b0;
    char_code    = '0;
    last         = 1'b0;
    quiet_mode   = 1'b0;
    hold_off_req = 0;
    chars_sent   = 0;
    refs_sent    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners
    send_string("A1");            // smallest column and row
    send_string("$XFD$1048576");  // largest column and row, both absolute
    send_string("1");             // digit with no letters
    send_string("$");             // ends without letters
    send_string("b");             // ends without digits
    send_string("abcd");          // fourth letter
    send_string("A0");            // row zero
    send_string("XFE1");          // column one past the last
    ref_text.delete();
    ref_text.push_back(8'hFF);    // non-ascii code
    send_reference();

    // random references
    random_chars = 0;
    while (random_chars < RANDOM_CHARS) begin
      if (random_chars >= 150 && hold_off_req == 0) hold_off_req <= 1;
      if (random_chars >= 800 && hold_off_req == 1) hold_off_req <= 2;
      quiet_mode <= (random_chars >= 400 && random_chars < 600);
      build_random_reference();
      random_chars += ref_text.size();
      send_reference();
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d characters in %0d references, %0d results compared",
             chars_sent, refs_sent, checked_count);
    $display("random idling on both sides, one stretch without it, two long result stalls");
    if (error_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
